// ===== hw/rtl/tms_pkg.sv =====
// Shared types, constants and helpers of the transform matrix stack.
package tms_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int ELEM_W    = 32;
    localparam int ELEMS     = 16;
    localparam int LVL_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ADDR_W    = LVL_W + 5;
    localparam int RAM_DEPTH = STACK_DEPTH * 2 * ELEMS;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + 2;

    localparam logic [ELEM_W-1:0] FX_ONE = ELEM_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0]  LVL_MAX = LVL_W'(STACK_DEPTH - 1);

    localparam logic [2:0] ACT_MODE  = 3'd0;
    localparam logic [2:0] ACT_IDENT = 3'd1;
    localparam logic [2:0] ACT_STAGE = 3'd2;
    localparam logic [2:0] ACT_LOAD  = 3'd3;
    localparam logic [2:0] ACT_MULT  = 3'd4;
    localparam logic [2:0] ACT_PUSH  = 3'd5;
    localparam logic [2:0] ACT_POP   = 3'd6;

    localparam logic [1:0] MODE_PROJ = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               action;
        logic [1:0]               mode;
        logic [3:0]               element_index;
        logic signed [ELEM_W-1:0] element_value;
    } tms_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] top_value;
        logic [4:0]               stack_level;
        logic [1:0]               status;
    } tms_out_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tms_mac_ctrl_t;

    // Element of the identity matrix at a column-major position.
    function automatic logic [ELEM_W-1:0] ident_elem(input logic [3:0] e);
        logic diag;
        diag = (e == 4'd0) || (e == 4'd5) || (e == 4'd10) || (e == 4'd15);
        return diag ? FX_ONE : '0;
    endfunction

endpackage

// ===== hw/rtl/tms_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tms_mac.sv =====
// Fixed-point multiply-accumulate unit with truncated products and a saturated sum.
module tms_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tms_pkg::tms_mac_ctrl_t             ctrl,
    input  logic signed [tms_pkg::ELEM_W-1:0]  a,
    input  logic signed [tms_pkg::ELEM_W-1:0]  b,
    output logic                               res_valid,
    output logic signed [tms_pkg::ELEM_W-1:0]  res
);

    localparam int EW = tms_pkg::ELEM_W;
    localparam int PW = tms_pkg::PROD_W;
    localparam int AW = tms_pkg::ACC_W;
    localparam int FB = tms_pkg::FRAC_BITS;

    logic signed [PW-1:0] a_ext;
    logic signed [PW-1:0] b_ext;
    logic signed [PW-1:0] prod_reg;
    logic                 p_valid_reg;
    logic                 p_first_reg;
    logic                 p_last_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] term;
    logic [EW-1:0]        sat;
    logic                 res_valid_reg;
    logic [EW-1:0]        res_reg;

    assign a_ext = {{(PW-EW){a[EW-1]}}, a};
    assign b_ext = {{(PW-EW){b[EW-1]}}, b};

    // Dropping the low fraction bits of a two's complement product rounds
    // toward minus infinity.
    assign term     = {{2{prod_reg[PW-1]}}, prod_reg[PW-1:FB]};
    assign acc_next = (p_first_reg ? '0 : acc_reg) + term;

    always_comb begin
        if ((&acc_next[AW-1:EW-1]) || !(|acc_next[AW-1:EW-1])) begin
            sat = acc_next[EW-1:0];
        end else if (acc_next[AW-1]) begin
            sat = {1'b1, {(EW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(EW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            p_first_reg   <= 1'b0;
            p_last_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            p_valid_reg   <= ctrl.valid;
            p_first_reg   <= ctrl.first;
            p_last_reg    <= ctrl.last;
            res_valid_reg <= p_valid_reg && p_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_ext * b_ext;
        if (p_valid_reg) begin
            acc_reg <= acc_next;
        end
        if (p_valid_reg && p_last_reg) begin
            res_reg <= sat;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/transform_matrix_stack.sv =====
// Top level: two 4x4 fixed-point matrix stacks held in one RAM, with a sequencer.
// A new transaction is taken in the cycle after the previous result is registered.
// Every stored element moves through the single RAM write port, at most one per cycle,
// and the multiply runs its 64 products through one multiply-accumulate unit.
// Reset is synchronous; slot 0 reads as identity through per-element flags, no RAM pass.
module transform_matrix_stack (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tms_pkg::tms_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tms_pkg::tms_out_t m_data
);

    localparam int EW = tms_pkg::ELEM_W;
    localparam int LW = tms_pkg::LVL_W;
    localparam int NE = tms_pkg::ELEMS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_COPY = 4'd2;
    localparam logic [3:0] ST_CPYL = 4'd3;
    localparam logic [3:0] ST_MRD  = 4'd4;
    localparam logic [3:0] ST_MRDL = 4'd5;
    localparam logic [3:0] ST_MAC  = 4'd6;
    localparam logic [3:0] ST_MDRN = 4'd7;
    localparam logic [3:0] ST_RD   = 4'd8;
    localparam logic [3:0] ST_RDW  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [3:0]              cnt_reg;
    logic [1:0]              row_reg;
    logic [1:0]              wcol_reg;
    logic [2:0]              act_reg;
    logic [3:0]              idx_reg;
    logic [1:0]              status_reg;
    logic [1:0]              mode_reg;
    logic [LW-1:0]           mv_lvl_reg;
    logic [LW-1:0]           pj_lvl_reg;
    logic signed [EW-1:0]    staged_reg [NE];
    logic signed [EW-1:0]    rowbuf_reg [4];
    logic [1:0][NE-1:0]      vbit_reg;
    logic                    cpy_pend_reg;
    logic [3:0]              cpy_e_reg;
    logic                    rb_pend_reg;
    logic [1:0]              rb_k_reg;
    logic                    rd_id_reg;
    logic [3:0]              rd_e_reg;
    logic [EW-1:0]           val_reg;
    logic                    m_valid_reg;
    tms_pkg::tms_out_t       m_data_reg;

    logic                    sel;
    logic [LW-1:0]           lvl;
    logic [LW+4:0]           lvl_wide;
    logic                    out_free;
    logic [3:0]              rd_e;
    logic                    rd_id_next;
    logic [tms_pkg::ADDR_W-1:0] raddr;
    logic [tms_pkg::ADDR_W-1:0] waddr;
    logic                    we;
    logic [LW-1:0]           w_lvl;
    logic [3:0]              w_e;
    logic [EW-1:0]           wdata;
    logic [EW-1:0]           ram_rdata;
    logic [EW-1:0]           rdata_eff;
    tms_pkg::tms_mac_ctrl_t  mac_ctrl;
    logic                    mac_res_valid;
    logic signed [EW-1:0]    mac_res;

    assign sel      = (mode_reg == tms_pkg::MODE_PROJ);
    assign lvl      = sel ? pj_lvl_reg : mv_lvl_reg;
    assign lvl_wide = {5'd0, lvl};
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Read side: an element of slot 0 that was never written reads as identity.
    always_comb begin
        case (state_reg)
            ST_COPY: rd_e = cnt_reg;
            ST_MRD:  rd_e = {cnt_reg[1:0], row_reg};
            default: rd_e = idx_reg;
        endcase
    end

    assign raddr      = {lvl, sel, rd_e};
    assign rd_id_next = (lvl == '0) && !vbit_reg[sel][rd_e];
    assign rdata_eff  = rd_id_reg ? tms_pkg::ident_elem(rd_e_reg) : ram_rdata;

    // Write side: fill, push copy and multiply results never overlap in time.
    always_comb begin
        we    = 1'b0;
        w_lvl = lvl;
        w_e   = cnt_reg;
        wdata = tms_pkg::ident_elem(cnt_reg);
        if (state_reg == ST_FILL) begin
            we = 1'b1;
            if (act_reg == tms_pkg::ACT_LOAD) begin
                wdata = staged_reg[cnt_reg];
            end
        end
        if (cpy_pend_reg) begin
            we    = 1'b1;
            w_lvl = lvl + LW'(1);
            w_e   = cpy_e_reg;
            wdata = rdata_eff;
        end
        if (mac_res_valid) begin
            we    = 1'b1;
            w_e   = {wcol_reg, row_reg};
            wdata = mac_res;
        end
    end

    assign waddr = {w_lvl, sel, w_e};

    // Element (c, row) of the product uses row "row" of the top and column c
    // of the staged operand; cnt_reg walks c in its high bits and k in its low.
    assign mac_ctrl.valid = (state_reg == ST_MAC);
    assign mac_ctrl.first = (cnt_reg[1:0] == 2'd0);
    assign mac_ctrl.last  = (cnt_reg[1:0] == 2'd3);

    tms_ram #(
        .WIDTH (EW),
        .DEPTH (tms_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    tms_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mac_ctrl),
        .a         (rowbuf_reg[cnt_reg[1:0]]),
        .b         (staged_reg[cnt_reg]),
        .res_valid (mac_res_valid),
        .res       (mac_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.action)
                        tms_pkg::ACT_IDENT: state_next = ST_FILL;
                        tms_pkg::ACT_LOAD:  state_next = ST_FILL;
                        tms_pkg::ACT_MULT:  state_next = ST_MRD;
                        tms_pkg::ACT_PUSH:  state_next = (lvl < tms_pkg::LVL_MAX) ? ST_COPY : ST_RD;
                        default:            state_next = ST_RD;
                    endcase
                end
            end
            ST_FILL: if (cnt_reg == 4'd15) state_next = ST_RD;
            ST_COPY: if (cnt_reg == 4'd15) state_next = ST_CPYL;
            ST_CPYL: state_next = ST_RD;
            ST_MRD:  if (cnt_reg[1:0] == 2'd3) state_next = ST_MRDL;
            ST_MRDL: state_next = ST_MAC;
            ST_MAC:  if (cnt_reg == 4'd15) state_next = ST_MDRN;
            ST_MDRN: begin
                if (mac_res_valid && (wcol_reg == 2'd3)) begin
                    state_next = (row_reg == 2'd3) ? ST_RD : ST_MRD;
                end
            end
            ST_RD:   state_next = ST_RDW;
            ST_RDW:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            row_reg      <= '0;
            wcol_reg     <= '0;
            mode_reg     <= '0;
            mv_lvl_reg   <= '0;
            pj_lvl_reg   <= '0;
            vbit_reg     <= '0;
            cpy_pend_reg <= 1'b0;
            rb_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NE; i++) begin
                staged_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cpy_pend_reg <= (state_reg == ST_COPY);
            rb_pend_reg  <= (state_reg == ST_MRD);
            if (we && (w_lvl == '0)) begin
                vbit_reg[sel][w_e] <= 1'b1;
            end
            if (mac_res_valid) begin
                wcol_reg <= wcol_reg + 2'd1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cnt_reg <= '0;
                        row_reg <= '0;
                        if (s_data.action == tms_pkg::ACT_MODE) begin
                            mode_reg <= s_data.mode;
                        end
                        if (s_data.action == tms_pkg::ACT_STAGE) begin
                            staged_reg[s_data.element_index] <= s_data.element_value;
                        end
                        if ((s_data.action == tms_pkg::ACT_POP) && (lvl != '0)) begin
                            if (sel) begin
                                pj_lvl_reg <= pj_lvl_reg - LW'(1);
                            end else begin
                                mv_lvl_reg <= mv_lvl_reg - LW'(1);
                            end
                        end
                    end
                end
                ST_FILL, ST_COPY, ST_MRD, ST_MAC: cnt_reg <= cnt_reg + 4'd1;
                ST_CPYL: begin
                    if (sel) begin
                        pj_lvl_reg <= pj_lvl_reg + LW'(1);
                    end else begin
                        mv_lvl_reg <= mv_lvl_reg + LW'(1);
                    end
                end
                ST_MRDL: cnt_reg <= '0;
                ST_MDRN: begin
                    if (mac_res_valid && (wcol_reg == 2'd3)) begin
                        row_reg <= row_reg + 2'd1;
                        cnt_reg <= '0;
                    end
                end
                default: ;
            endcase
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cpy_e_reg <= cnt_reg;
        rb_k_reg  <= cnt_reg[1:0];
        rd_id_reg <= rd_id_next;
        rd_e_reg  <= rd_e;
        if (rb_pend_reg) begin
            rowbuf_reg[rb_k_reg] <= rdata_eff;
        end
        if ((state_reg == ST_IDLE) && s_valid) begin
            act_reg    <= s_data.action;
            idx_reg    <= s_data.element_index;
            if ((s_data.action == tms_pkg::ACT_PUSH) && !(lvl < tms_pkg::LVL_MAX)) begin
                status_reg <= tms_pkg::STATUS_FULL;
            end else if ((s_data.action == tms_pkg::ACT_POP) && (lvl == '0)) begin
                status_reg <= tms_pkg::STATUS_EMPTY;
            end else begin
                status_reg <= tms_pkg::STATUS_OK;
            end
        end
        if (state_reg == ST_RDW) begin
            val_reg <= rdata_eff;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.top_value   <= val_reg;
            m_data_reg.stack_level <= lvl_wide[4:0];
            m_data_reg.status      <= status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_idle_no_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_res_valid)
        else $error("multiply result arrived while idle");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_lvl_reg <= tms_pkg::LVL_MAX) && (pj_lvl_reg <= tms_pkg::LVL_MAX))
        else $error("stack level beyond the last slot");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_copy_not_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        cpy_pend_reg |-> (we && (w_lvl != '0)))
        else $error("push copy aimed at slot zero");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("transaction accepted without starting work");

endmodule
